// File: rtl/blb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blb_pkg: shared types and constants of the battery level LED bar
// Register indexes, field widths, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package blb_pkg;

  // Number of levels scanned; only the threshold registers that exist count
  localparam int unsigned LEVELS     = 5;
  localparam int unsigned NUM_THRESH = 5;
  localparam int unsigned SCAN_TOP   = (LEVELS < NUM_THRESH) ? LEVELS : NUM_THRESH;

  localparam int unsigned MV_W    = 16;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned BAR_W   = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values
  localparam int unsigned THR_STEP_MV       = 2000;
  localparam logic [CNT_W-1:0] BLINK_RST    = 8'd5;
  localparam logic [CNT_W-1:0] REFRESH_RST  = 8'd10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THR_1     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_5     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH   = 3'd6;

  typedef logic [MV_W-1:0]    mv_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [BAR_W-1:0]   bar_t;

  typedef struct packed {
    logic [NUM_THRESH-1:0][MV_W-1:0] thr;
    logic [CNT_W-1:0]                blink_ticks;
    logic [CNT_W-1:0]                refresh_limit;
  } cfg_t;

endpackage

// File: rtl/blb_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blb_cfg: configuration register file
// Holds the five thresholds, the blink period and the refresh limit.
// ----------------------------------------------------------------------------
module blb_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [blb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [blb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output blb_pkg::cfg_t                    cfg_o
);

  blb_pkg::cfg_t cfg_q;

  // Write one register; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < blb_pkg::NUM_THRESH; i++) begin
        cfg_q.thr[i] <= blb_pkg::MV_W'((i + 1) * blb_pkg::THR_STEP_MV);
      end
      cfg_q.blink_ticks   <= blb_pkg::BLINK_RST;
      cfg_q.refresh_limit <= blb_pkg::REFRESH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i) inside
        [blb_pkg::CFG_THR_1:blb_pkg::CFG_THR_5]: begin
          cfg_q.thr[cfg_idx_i] <= cfg_data_i[blb_pkg::MV_W-1:0];
        end
        blb_pkg::CFG_BLINK: begin
          cfg_q.blink_ticks <= cfg_data_i[blb_pkg::CNT_W-1:0];
        end
        blb_pkg::CFG_REFRESH: begin
          cfg_q.refresh_limit <= cfg_data_i[blb_pkg::CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/blb_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blb_level: voltage to level
// Parallel threshold compares; the highest-numbered threshold met sets the level.
// ----------------------------------------------------------------------------
module blb_level (
  input  blb_pkg::mv_t    voltage_mv_i,
  input  blb_pkg::cfg_t   cfg_i,
  output blb_pkg::level_t level_o
);

  // Scan upward so that the highest match wins
  always_comb begin
    level_o = '0;
    for (int i = 0; i < blb_pkg::SCAN_TOP; i++) begin
      if (voltage_mv_i >= cfg_i.thr[i]) begin
        level_o = blb_pkg::LEVEL_W'(i + 1);
      end
    end
  end

endmodule

// File: rtl/blb_bar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blb_bar: blink and refresh counters with the bar register
// Advances the counters once per tick and redraws the bar on refresh.
// ----------------------------------------------------------------------------
module blb_bar (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tick_i,
  input  blb_pkg::cfg_t   cfg_i,
  input  blb_pkg::level_t level_i,
  input  logic            charging_i,
  input  logic            fault_i,
  output blb_pkg::bar_t   bar_o
);

  logic [blb_pkg::CNT_W-1:0] blink_q, blink_d, blink_inc;
  logic [blb_pkg::CNT_W-1:0] refresh_q, refresh_d;
  logic [blb_pkg::CNT_W:0]   refresh_inc;
  logic                      off_q, off_d;
  blb_pkg::bar_t             bar_q, bar_d, drawn;
  logic                      on_phase, top_lit, redraw;
  blb_pkg::level_t           top_idx;

  // Blink counter: flip the phase when the count reaches the period
  always_comb begin
    blink_inc = blink_q + 1'b1;
    blink_d   = blink_inc;
    off_d     = off_q;
    if (blink_inc == cfg_i.blink_ticks) begin
      blink_d = '0;
      off_d   = ~off_q;
    end
  end

  // Refresh counter: redraw once the count passes the limit
  always_comb begin
    refresh_inc = {1'b0, refresh_q} + 1'b1;
    redraw      = refresh_inc > {1'b0, cfg_i.refresh_limit};
    refresh_d   = redraw ? '0 : refresh_inc[blb_pkg::CNT_W-1:0];
  end

  // Draw the bar with the updated phase
  always_comb begin
    on_phase = ~off_d;
    top_lit  = charging_i ? on_phase : 1'b1;
    top_idx  = (level_i == '0) ? '0 : level_i - 1'b1;
    for (int j = 0; j < blb_pkg::BAR_W; j++) begin
      drawn[j] = (blb_pkg::LEVEL_W'(j) < top_idx)
               | ((blb_pkg::LEVEL_W'(j) == top_idx) & top_lit);
    end
    if (fault_i) begin
      drawn = {blb_pkg::BAR_W{on_phase}};
    end
    bar_d = redraw ? drawn : bar_q;
  end

  // Hold state between ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_q   <= '0;
      refresh_q <= '0;
      off_q     <= 1'b1;
      bar_q     <= '0;
    end else if (tick_i) begin
      blink_q   <= blink_d;
      refresh_q <= refresh_d;
      off_q     <= off_d;
      bar_q     <= bar_d;
    end
  end

  assign bar_o = bar_d;

endmodule

// File: rtl/battery_level_led_bar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_led_bar_top: battery level LED bar gauge
// Takes one tick per transfer and returns the LED bar, level and charge LED.
//
//   channel   dir  bits  contents
//   s_axis    in   24    voltage_mv, charging, fault
//   m_axis    out  16    led_bar, level, charge_led
//   cfg       in   3/16  register index, write data
//
// An accepted tick lands in the input register and its result moves to the
// output register; one tick per cycle is sustained while m_axis_tready is high.
// The output register is the only place a result waits; the input register
// keeps taking ticks while m_axis_tready is high or the output is empty.
// Reset clears both valid flags and the counters, and sets the blink phase off.
// ----------------------------------------------------------------------------
module battery_level_led_bar_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Fields from bit 0: voltage_mv[15:0], charging[16], fault[17], zero fill
  input  logic [23:0]                    s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: led_bar[4:0], level[7:5], charge_led[8], zero fill
  output logic [15:0]                    m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [blb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [blb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  blb_pkg::cfg_t   cfg;
  logic            in_valid_q;
  blb_pkg::mv_t    in_mv_q;
  logic            in_chg_q, in_flt_q;
  logic            out_valid_q;
  blb_pkg::bar_t   out_bar_q;
  blb_pkg::level_t out_level_q, level;
  logic            out_chg_q;
  blb_pkg::bar_t   bar;
  logic            out_free, advance;

  assign out_free      = ~out_valid_q | m_axis_tready;
  assign advance       = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | out_free;

  blb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  blb_level u_level (
    .voltage_mv_i (in_mv_q),
    .cfg_i        (cfg),
    .level_o      (level)
  );

  blb_bar u_bar (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (advance),
    .cfg_i      (cfg),
    .level_i    (level),
    .charging_i (in_chg_q),
    .fault_i    (in_flt_q),
    .bar_o      (bar)
  );

  // Input register: take a transfer whenever the stage can move on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready & s_axis_tvalid) begin
      in_mv_q  <= s_axis_tdata[15:0];
      in_chg_q <= s_axis_tdata[16];
      in_flt_q <= s_axis_tdata[17];
    end
  end

  // Result register: hold while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_bar_q   <= bar;
      out_level_q <= level;
      out_chg_q   <= in_chg_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_chg_q, out_level_q, out_bar_q};

`ifndef SYNTH
  // Backpressure only when both registers are full and the sink stalls
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  // A tick that moves on shows up as a valid result next cycle
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced tick lost");

  // A valid result never reports a level above the scanned range
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_level_q <= blb_pkg::LEVEL_W'(blb_pkg::SCAN_TOP)))
    else $error("level out of range");
`endif

endmodule

// File: tb/blb_gauge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blb_gauge_checker: reading predictor and result check for the LED bar gauge
// Watches the tick stream, the register writes and the result stream. Keeps
// its own copy of the gauge settings, counters, blink phase and bar, works out
// the reading each accepted tick must produce, and compares every result
// transfer field by field against the oldest reading still owed.
// ----------------------------------------------------------------------------
module blb_gauge_checker
  import blb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Fields from bit 0: voltage_mv[15:0], charging[16], fault[17], zero fill
  input  logic [23:0]           s_axis_tdata,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // Fields from bit 0: led_bar[4:0], level[7:5], charge_led[8], zero fill
  input  logic [15:0]           m_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    errors_o
);

  typedef struct packed {
    bar_t   led_bar;
    level_t level;
    logic   charge_led;
  } reading_t;

  // Gauge settings as last written
  mv_t              thr_mv [NUM_THRESH];
  logic [CNT_W-1:0] blink_ticks_q;
  logic [CNT_W-1:0] refresh_limit_q;

  // Gauge state
  logic [CNT_W-1:0] blink_cnt;
  logic [CNT_W-1:0] refresh_cnt;
  logic             off_phase;
  bar_t             bar_q;

  reading_t expected_readings [$];
  int       fail_tally = 0;
  int       readings_owed = 0;

  assign pending_o = readings_owed;
  assign errors_o  = fail_tally;

  // Advance the gauge by one tick and return the reading it shows
  function automatic reading_t step_gauge(mv_t volts, logic chg, logic flt);
    reading_t       r;
    level_t         lvl;
    logic           lit_top;
    logic [CNT_W:0] next_refresh;
    lvl = '0;
    for (int i = SCAN_TOP; i > 0; i--) begin
      if (lvl == '0 && volts >= thr_mv[i-1]) lvl = level_t'(i);
    end

    blink_cnt = blink_cnt + 1'b1;
    if (blink_cnt == blink_ticks_q) begin
      off_phase = ~off_phase;
      blink_cnt = '0;
    end

    // Redraw with the updated phase once the refresh count passes its limit
    next_refresh = {1'b0, refresh_cnt} + 1'b1;
    if (next_refresh > {1'b0, refresh_limit_q}) begin
      refresh_cnt = '0;
      lit_top = chg ? ~off_phase : 1'b1;
      if (flt) bar_q = off_phase ? '0 : '1;
      else if (lvl == '0) bar_q = bar_t'(lit_top);
      else bar_q = ((bar_t'(1) << (lvl - 1)) - 1'b1) | (bar_t'(lit_top) << (lvl - 1));
    end else begin
      refresh_cnt = next_refresh[CNT_W-1:0];
    end

    r.led_bar    = bar_q;
    r.level      = lvl;
    r.charge_led = chg;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t got;
    reading_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_THRESH; i++) thr_mv[i] = mv_t'((i + 1) * THR_STEP_MV);
      blink_ticks_q   = BLINK_RST;
      refresh_limit_q = REFRESH_RST;
      blink_cnt       = '0;
      refresh_cnt     = '0;
      off_phase       = 1'b1;
      bar_q           = '0;
      expected_readings.delete();
    end else begin
      // Track register writes; indexes past the last register are dropped
      if (cfg_we_i) begin
        if (cfg_idx_i <= CFG_THR_5) thr_mv[cfg_idx_i - CFG_THR_1] = cfg_data_i;
        else if (cfg_idx_i == CFG_BLINK) blink_ticks_q = cfg_data_i[CNT_W-1:0];
        else if (cfg_idx_i == CFG_REFRESH) refresh_limit_q = cfg_data_i[CNT_W-1:0];
      end

      // Check a result transfer against the oldest owed reading
      if (m_axis_tvalid && m_axis_tready) begin
        got.led_bar    = m_axis_tdata[4:0];
        got.level      = m_axis_tdata[7:5];
        got.charge_led = m_axis_tdata[8];
        if (expected_readings.size() == 0) begin
          if (fail_tally < 10)
            $display("%0t: result with no reading owed: bar %b level %0d charge %b",
                     $realtime, got.led_bar, got.level, got.charge_led);
          fail_tally++;
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            if (fail_tally < 10)
              $display({"%0t: reading mismatch: expected bar %b level %0d charge %b,",
                        " got bar %b level %0d charge %b"}, $realtime,
                       want.led_bar, want.level, want.charge_led,
                       got.led_bar, got.level, got.charge_led);
            fail_tally++;
          end
        end
      end

      // Predict the reading of an accepted tick
      if (s_axis_tvalid && s_axis_tready)
        expected_readings.push_back(step_gauge(s_axis_tdata[15:0], s_axis_tdata[16],
                                               s_axis_tdata[17]));
    end
    readings_owed = expected_readings.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the battery level LED bar gauge
// Drives ticks through the input stream and register writes between phases,
// with random gaps and output stalls. A directed run covers band edges,
// charging, faults and extreme thresholds; random phases follow under many
// blink and refresh settings. The checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_top;
  import blb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = CFG_REFRESH + 1'b1;

  logic                  clk_i;
  logic                  rst_ni;
  logic [23:0]           s_axis_tdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int   readings_due;
  int   mismatch_total;
  int   cycle_count = 0;
  int   stall_left = 0;
  logic no_idle = 1'b0;
  mv_t  thr_shadow [NUM_THRESH];

  battery_level_led_bar_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  blb_gauge_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (readings_due),
    .errors_o      (mismatch_total)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly short idle stretches, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side at random, except in steady phases
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Present one tick, hold it until the transfer, then idle a while
  task automatic send_tick(input mv_t volts, input logic chg, input logic flt);
    int gap;
    @(negedge clk_i);
    s_axis_tdata  <= {6'd0, flt, chg, volts};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = no_idle ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // Drop valid and wait for every owed reading to come out
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (readings_due != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx <= CFG_THR_5) thr_shadow[idx - CFG_THR_1] = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Voltages cluster around the thresholds so every band edge is hit
  function automatic mv_t rand_voltage();
    int  r;
    mv_t base;
    r    = $urandom_range(0, 99);
    base = thr_shadow[$urandom_range(0, NUM_THRESH - 1)];
    if (r < 35) return base + mv_t'($urandom_range(0, 2)) - 1'b1;
    if (r < 45) return $urandom_range(0, 1) ? '0 : '1;
    return mv_t'($urandom);
  endfunction

  function automatic logic [CNT_W-1:0] rand_count(input int top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 18) return '1;
    return CNT_W'($urandom_range(1, top));
  endfunction

  // Rewrite a random subset of the registers; some phases force extremes
  task automatic load_random_settings(input int phase);
    logic [CNT_W-1:0] blink;
    logic [CNT_W-1:0] refresh;
    logic             ascending;
    mv_t              thr;
    ascending = 1'($urandom_range(0, 1));
    for (int i = 0; i < NUM_THRESH; i++) begin
      if (ascending) thr = mv_t'(i * 12000 + $urandom_range(0, 11999));
      else if ($urandom_range(0, 9) == 0) thr = '0;
      else if ($urandom_range(0, 9) == 0) thr = '1;
      else thr = mv_t'($urandom);
      if ($urandom_range(0, 4) != 0) write_reg(CFG_THR_1 + CFG_IDX_W'(i), thr);
    end
    blink   = (phase == 1) ? '0 : (phase == 2) ? '1 : rand_count(8);
    refresh = (phase == 1) ? '1 : (phase == 2) ? '0 : rand_count(6);
    if (phase < 3 || $urandom_range(0, 3) != 0)
      write_reg(CFG_BLINK, {CNT_W'($urandom), blink});
    if (phase < 3 || $urandom_range(0, 3) != 0)
      write_reg(CFG_REFRESH, {CNT_W'($urandom), refresh});
    if ($urandom_range(0, 3) == 0) write_reg(CFG_NONE, CFG_DATA_W'($urandom));
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_THR_1;
    cfg_data_i    = '0;
    for (int i = 0; i < NUM_THRESH; i++) thr_shadow[i] = mv_t'((i + 1) * THR_STEP_MV);
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: band edges, full scale, a fault
    send_tick(16'd0, 1'b0, 1'b0);
    send_tick(16'hFFFF, 1'b1, 1'b0);
    send_tick(16'd1999, 1'b1, 1'b0);
    send_tick(16'd2000, 1'b0, 1'b0);
    send_tick(16'd10000, 1'b0, 1'b1);
    send_tick(16'd9999, 1'b1, 1'b0);
    wait_idle();

    // Redraw and flip phase on every tick; upper data bits must be dropped
    write_reg(CFG_REFRESH, 16'hFF00);
    write_reg(CFG_BLINK, 16'hAB01);
    for (int lvl = 0; lvl <= NUM_THRESH; lvl++) begin
      send_tick(mv_t'(lvl * THR_STEP_MV), 1'b0, 1'b0);
      send_tick(mv_t'(lvl * THR_STEP_MV), 1'b1, 1'b0);
    end
    send_tick(16'd5000, 1'b1, 1'b1);
    send_tick(16'd5000, 1'b0, 1'b1);
    wait_idle();

    // Unused index is ignored; lowest and highest thresholds
    write_reg(CFG_NONE, 16'hFFFF);
    write_reg(CFG_THR_1, 16'd0);
    write_reg(CFG_THR_5, 16'hFFFF);
    send_tick(16'd0, 1'b0, 1'b0);
    send_tick(16'hFFFF, 1'b0, 1'b0);
    send_tick(16'hFFFE, 1'b1, 1'b0);
    wait_idle();

    // Random phases, each under fresh settings
    for (int phase = 0; phase < 10; phase++) begin
      no_idle = (phase % 4 == 3);
      load_random_settings(phase);
      repeat (65) send_tick(rand_voltage(), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 99) < 15);
      wait_idle();
    end

    repeat (8) @(negedge clk_i);
    if (mismatch_total == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/blb_pkg.sv
rtl/blb_cfg.sv
rtl/blb_level.sv
rtl/blb_bar.sv
rtl/battery_level_led_bar_top.sv
tb/blb_gauge_checker.sv
tb/tb_top.sv
